@@ src/assert_macros.svh @@
// Assertion macros used by the formatter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, off while reset is asserted.
`define ASSERT_CLKD(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication whose consequent is checked in the next cycle, same clock and reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/ufmt_pkg.sv @@
// Types, character codes and helper functions of the unsigned-to-ASCII formatter.
package ufmt_pkg;

	localparam int DigitDepth = 20;
	localparam int DigitIdxW  = 5;

	// modes carried in tuser
	localparam logic [1:0] FUNC_DEC   = 2'd0;
	localparam logic [1:0] FUNC_HEX_L = 2'd1;
	localparam logic [1:0] FUNC_HEX_U = 2'd2;
	localparam logic [1:0] FUNC_PTR   = 2'd3;

	// floor(x / 10) == (x * RECIP_TEN) >> RECIP_SHIFT for any 32-bit x
	localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
	localparam int          RECIP_SHIFT = 35;

	localparam logic [7:0] CHAR_ZERO    = 8'h30;
	localparam logic [7:0] CHAR_X_LOWER = 8'h78;
	localparam logic [7:0] ALPHA_LOWER  = 8'h57; // 'a' - 10
	localparam logic [7:0] ALPHA_UPPER  = 8'h37; // 'A' - 10

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_NIL    = 6'b000010,
		ST_PREFIX = 6'b000100,
		ST_HEX    = 6'b001000,
		ST_MUL    = 6'b010000,
		ST_DIV    = 6'b100000
	} ext_state_t;

	typedef enum logic [1:0] {
		EM_IDLE  = 2'b01,
		EM_EMIT  = 2'b10
	} emit_state_t;

	function automatic logic [7:0] digit_char(input logic upper, input logic [3:0] d);
		logic [7:0] base;
		if (d < 4'd10) begin
			base = CHAR_ZERO;
		end else if (upper) begin
			base = ALPHA_UPPER;
		end else begin
			base = ALPHA_LOWER;
		end
		return base + {4'b0, d};
	endfunction

	function automatic logic [7:0] nil_char(input logic [2:0] idx);
		logic [7:0] c;
		unique case (idx)
			3'd0:    c = 8'h28; // (
			3'd1:    c = 8'h6E; // n
			3'd2:    c = 8'h69; // i
			3'd3:    c = 8'h6C; // l
			default: c = 8'h29; // )
		endcase
		return c;
	endfunction

endpackage

@@ src/unsigned_to_ascii_formatter.sv @@
// Unsigned-to-ASCII formatter: one value in, its decimal or hex text out a character at a time.
//
// Each input transfer carries a mode in s_tuser (0 decimal, 1 lowercase hex, 2 uppercase hex,
// 3 pointer) and a value in s_tdata. The block sends the text most significant character first,
// one character per output transfer, with no leading zeros; zero prints as "0", a null pointer as
// "(nil)", any other pointer as "0x" plus lowercase hex of all 64 bits. Modes 0..2 use bits 31..0.
// m_tlast marks the final character. Timing: one item is in flight at a time and s_tready stays
// low until its last character has been loaded into the output register. Digits are peeled off
// least significant first by one shared extraction unit: hex by a nibble shift per digit,
// decimal by a 32x32 reciprocal multiply, then a quotient/remainder correction. A fetch from
// the digit store follows, then characters leave at one per cycle while the sink keeps
// m_tready high. The next item is accepted in the cycle after the last character is loaded,
// even if it still waits in the output register.
`include "assert_macros.svh"

module unsigned_to_ascii_formatter (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // [63:0] value
	input  logic [1:0]  s_tuser,  // [1:0] func
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // [7:0] char_out
	output logic        m_tlast   // last character of the item
);

	localparam int IdxW = ufmt_pkg::DigitIdxW;

	// sequencer and working registers
	ufmt_pkg::ext_state_t  state_q;
	ufmt_pkg::emit_state_t emit_q;
	logic [1:0]            func_q;
	logic [63:0]           work_q;
	logic [63:0]           prod_q;
	logic [IdxW-1:0]       cnt_q;   // digits written so far
	logic [IdxW-1:0]       pos_q;   // digit being sent
	logic [2:0]            txt_q;   // index into "(nil)" / "0x"
	logic                  fetch_q; // digit store read in flight

	// digit store, least significant digit first
	logic [3:0]            dig_mem [ufmt_pkg::DigitDepth];
	logic [3:0]            rd_q;
	logic [IdxW-1:0]       rd_addr;
	logic                  dig_we;
	logic [3:0]            dig_wdata;

	// output register
	logic                  m_tvalid_q;
	logic [7:0]            m_tdata_q;
	logic                  m_tlast_q;

	logic                  in_xfer;
	logic                  out_free;
	logic                  ld;
	logic                  ld_last;
	logic [7:0]            ld_char;

	// decimal extraction datapath
	logic [28:0]           quo;
	logic [31:0]           quo_x10;
	logic [3:0]            rem;

	assign s_tready = (state_q == ufmt_pkg::ST_IDLE) && (emit_q == ufmt_pkg::EM_IDLE);
	assign in_xfer  = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	assign quo     = prod_q[63:ufmt_pkg::RECIP_SHIFT];
	assign quo_x10 = {quo, 3'b000} + {2'b00, quo, 1'b0};
	assign rem     = work_q[3:0] - quo_x10[3:0];

	// what the extraction unit writes into the digit store this cycle
	always_comb begin
		dig_we    = 1'b0;
		dig_wdata = work_q[3:0];
		unique case (state_q)
			ufmt_pkg::ST_HEX: begin
				dig_we = 1'b1;
			end
			ufmt_pkg::ST_DIV: begin
				dig_we    = 1'b1;
				dig_wdata = rem;
			end
			default: begin
				dig_we = 1'b0;
			end
		endcase
	end

	// character loaded into the output register this cycle
	always_comb begin
		ld      = 1'b0;
		ld_last = 1'b0;
		ld_char = ufmt_pkg::CHAR_ZERO;
		if (out_free) begin
			priority if (state_q == ufmt_pkg::ST_NIL) begin
				ld      = 1'b1;
				ld_char = ufmt_pkg::nil_char(txt_q);
				ld_last = (txt_q == 3'd4);
			end else if (state_q == ufmt_pkg::ST_PREFIX) begin
				ld      = 1'b1;
				ld_char = (txt_q == 3'd0) ? ufmt_pkg::CHAR_ZERO : ufmt_pkg::CHAR_X_LOWER;
			end else if (emit_q == ufmt_pkg::EM_EMIT && !fetch_q) begin
				ld      = 1'b1;
				ld_char = ufmt_pkg::digit_char(func_q == ufmt_pkg::FUNC_HEX_U, rd_q);
				ld_last = (pos_q == '0);
			end else begin
				ld = 1'b0;
			end
		end
	end

	// read the next digit as the current one leaves
	assign rd_addr = (ld && emit_q == ufmt_pkg::EM_EMIT && pos_q != '0) ? pos_q - 1'b1 : pos_q;

	always_ff @(posedge clk) begin
		if (dig_we) begin
			dig_mem[cnt_q] <= dig_wdata;
		end
		rd_q <= dig_mem[rd_addr];
	end

	// extraction sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ufmt_pkg::ST_IDLE;
			emit_q  <= ufmt_pkg::EM_IDLE;
			fetch_q <= 1'b0;
			func_q  <= ufmt_pkg::FUNC_DEC;
			work_q  <= '0;
			cnt_q   <= '0;
			pos_q   <= '0;
			txt_q   <= '0;
		end else begin
			fetch_q <= 1'b0;
			unique case (state_q)
				ufmt_pkg::ST_IDLE: begin
					if (in_xfer) begin
						func_q <= s_tuser;
						cnt_q  <= '0;
						txt_q  <= '0;
						if (s_tuser == ufmt_pkg::FUNC_PTR) begin
							work_q  <= s_tdata;
							state_q <= (s_tdata == '0) ? ufmt_pkg::ST_NIL : ufmt_pkg::ST_PREFIX;
						end else begin
							work_q  <= {32'b0, s_tdata[31:0]};
							state_q <= (s_tuser == ufmt_pkg::FUNC_DEC) ? ufmt_pkg::ST_MUL
							                                           : ufmt_pkg::ST_HEX;
						end
					end
				end
				ufmt_pkg::ST_NIL: begin
					if (ld) begin
						txt_q <= txt_q + 3'd1;
						if (ld_last) begin
							state_q <= ufmt_pkg::ST_IDLE;
						end
					end
				end
				ufmt_pkg::ST_PREFIX: begin
					if (ld) begin
						txt_q <= txt_q + 3'd1;
						if (txt_q != 3'd0) begin
							state_q <= ufmt_pkg::ST_HEX;
						end
					end
				end
				ufmt_pkg::ST_HEX: begin
					cnt_q  <= cnt_q + 1'b1;
					work_q <= {4'b0, work_q[63:4]};
					if (work_q[63:4] == '0) begin
						pos_q   <= cnt_q;
						fetch_q <= 1'b1;
						emit_q  <= ufmt_pkg::EM_EMIT;
						state_q <= ufmt_pkg::ST_IDLE;
					end
				end
				ufmt_pkg::ST_MUL: begin
					state_q <= ufmt_pkg::ST_DIV;
				end
				ufmt_pkg::ST_DIV: begin
					cnt_q  <= cnt_q + 1'b1;
					work_q <= {35'b0, quo};
					if (quo == '0) begin
						pos_q   <= cnt_q;
						fetch_q <= 1'b1;
						emit_q  <= ufmt_pkg::EM_EMIT;
						state_q <= ufmt_pkg::ST_IDLE;
					end else begin
						state_q <= ufmt_pkg::ST_MUL;
					end
				end
				default: begin
					state_q <= ufmt_pkg::ST_IDLE;
				end
			endcase

			// digit send-out, runs after extraction has finished
			if (emit_q == ufmt_pkg::EM_EMIT && ld) begin
				if (pos_q == '0) begin
					emit_q <= ufmt_pkg::EM_IDLE;
				end else begin
					pos_q <= pos_q - 1'b1;
				end
			end
		end
	end

	// reciprocal product, one register before the correction step
	always_ff @(posedge clk) begin
		prod_q <= work_q[31:0] * ufmt_pkg::RECIP_TEN;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (ld) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			m_tdata_q <= ld_char;
			m_tlast_q <= ld_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	// checks
	`ASSERT_CLKD(a_state_onehot, $onehot(state_q), "extraction state not one-hot")
	`ASSERT_CLKD(a_pos_range, (emit_q != ufmt_pkg::EM_EMIT) || (pos_q < cnt_q),
		"digit position beyond digits written")
	`ASSERT_NEXT(a_last_frees_input, ld && ld_last, s_tready,
		"input not ready after last character loaded")
	`ASSERT_NEXT(a_dec_start, in_xfer && s_tuser == ufmt_pkg::FUNC_DEC,
		state_q == ufmt_pkg::ST_MUL, "decimal item did not start extraction")

endmodule
